[hdl/fwrmd_pkg.sv]
// shared types, codes and helpers for the four-wheel ramped motor drive
`timescale 1ns / 1ps

package fwrmd_pkg;

    localparam int NUM_MOTORS = 4;

    // motor slots
    localparam int MOT_FL = 0;
    localparam int MOT_RL = 1;
    localparam int MOT_FR = 2;
    localparam int MOT_RR = 3;

    typedef logic signed [8:0] t_speed;

    typedef enum logic [2:0] {
        ACT_TICK           = 3'd0,
        ACT_MOTION         = 3'd1,
        ACT_SET_TARGETS    = 3'd2,
        ACT_GENTLE_STOP    = 3'd3,
        ACT_EMERGENCY_STOP = 3'd4
    } t_action;

    typedef enum logic [2:0] {
        MOV_STOP         = 3'd0,
        MOV_FORWARD      = 3'd1,
        MOV_BACKWARD     = 3'd2,
        MOV_TURN_LEFT    = 3'd3,
        MOV_TURN_RIGHT   = 3'd4,
        MOV_ROTATE_LEFT  = 3'd5,
        MOV_ROTATE_RIGHT = 3'd6
    } t_motion;

    // bridge input codes
    localparam logic [1:0] DIR_OFF = 2'd0;
    localparam logic [1:0] DIR_FWD = 2'd1;
    localparam logic [1:0] DIR_REV = 2'd2;

    // configuration port
    localparam int CFG_INDEX_W = 3;
    localparam int CFG_DATA_W  = 16;

    localparam logic [CFG_INDEX_W-1:0] CFG_MAX_SPEED     = 3'd0;
    localparam logic [CFG_INDEX_W-1:0] CFG_ACCEL_STEP    = 3'd1;
    localparam logic [CFG_INDEX_W-1:0] CFG_DECEL_STEP    = 3'd2;
    localparam logic [CFG_INDEX_W-1:0] CFG_RAMP_INTERVAL = 3'd3;
    localparam logic [CFG_INDEX_W-1:0] CFG_INVERT_MASK   = 3'd4;

    localparam logic [7:0]  RST_MAX_SPEED     = 8'd255;
    localparam logic [7:0]  RST_ACCEL_STEP    = 8'd4;
    localparam logic [7:0]  RST_DECEL_STEP    = 8'd8;
    localparam logic [15:0] RST_RAMP_INTERVAL = 16'd10;
    localparam logic [3:0]  RST_INVERT_MASK   = 4'd0;

    // inner wheel of a turn: floor(s * 45 / 100) = (s * 45 * 5243) >> 19, exact for s < 256
    localparam int          INNER_MUL_W = 18;
    localparam int          INNER_PROD_W = 26;
    localparam int          INNER_SHIFT = 19;
    localparam logic [INNER_MUL_W-1:0] INNER_MUL = 18'd235935;

    typedef struct packed {
        logic       load;
        logic [7:0] peak;
    } t_tgt_ctl;

    function automatic logic [7:0] f_mag(input t_speed v);
        logic [8:0] a;
        if (v[8]) begin
            a = 9'(-v);
        end else begin
            a = 9'(v);
        end
        return a[7:0];
    endfunction

endpackage

[hdl/fwrmd_ifs.sv]
// request and result channel interfaces of the motor drive
`timescale 1ns / 1ps

interface fwrmd_cmd_if;
    logic               valid;
    logic               ready;
    logic [2:0]         action;
    logic [2:0]         motion;
    logic [7:0]         speed;
    logic signed [15:0] front_left;
    logic signed [15:0] rear_left;
    logic signed [15:0] front_right;
    logic signed [15:0] rear_right;

    modport source (
        output valid, action, motion, speed, front_left, rear_left, front_right, rear_right,
        input  ready
    );
    modport sink (
        input  valid, action, motion, speed, front_left, rear_left, front_right, rear_right,
        output ready
    );
endinterface

interface fwrmd_res_if;
    logic       valid;
    logic       ready;
    logic [7:0] duty_front_left;
    logic [7:0] duty_rear_left;
    logic [7:0] duty_front_right;
    logic [7:0] duty_rear_right;
    logic [1:0] dir_front_left;
    logic [1:0] dir_rear_left;
    logic [1:0] dir_front_right;
    logic [1:0] dir_rear_right;
    logic       standby_on;
    logic [7:0] commanded_speed;
    logic       moving;

    modport source (
        output valid, duty_front_left, duty_rear_left, duty_front_right, duty_rear_right,
               dir_front_left, dir_rear_left, dir_front_right, dir_rear_right,
               standby_on, commanded_speed, moving,
        input  ready
    );
    modport sink (
        input  valid, duty_front_left, duty_rear_left, duty_front_right, duty_rear_right,
               dir_front_left, dir_rear_left, dir_front_right, dir_rear_right,
               standby_on, commanded_speed, moving,
        output ready
    );
endinterface

[hdl/four_wheel_ramped_motor_drive.sv]
// pipeline: an accepted request passes the input register, then the result register
// throughput: one request per cycle; a result held by the sink stalls the input once the
//   input register also holds a request
// reset: synchronous active-low i_rst_n zeroes all speeds, targets, peak, tick count and
//   standby, and loads the register defaults
`timescale 1ns / 1ps

module four_wheel_ramped_motor_drive (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    input  logic                                i_cfg_we,
    input  logic [fwrmd_pkg::CFG_INDEX_W-1:0]   i_cfg_index,
    input  logic [fwrmd_pkg::CFG_DATA_W-1:0]    i_cfg_data,
    fwrmd_cmd_if.sink                           i_cmd,
    fwrmd_res_if.source                         o_res
);

    localparam int NM = fwrmd_pkg::NUM_MOTORS;

    // configuration
    logic [7:0]  r_max_speed;
    logic [7:0]  r_accel_step;
    logic [7:0]  r_decel_step;
    logic [15:0] r_ramp_interval;
    logic [3:0]  r_invert_mask;

    // input register
    logic               r_in_valid;
    logic [2:0]         r_action;
    logic [2:0]         r_motion;
    logic [7:0]         r_speed;
    logic signed [15:0] r_raw [NM];

    // drive state
    fwrmd_pkg::t_speed r_tgt [NM];
    fwrmd_pkg::t_speed r_cur [NM];
    logic [7:0]        r_peak;
    logic [15:0]       r_ticks;
    logic              r_standby;

    fwrmd_pkg::t_speed n_tgt [NM];
    fwrmd_pkg::t_speed n_cur [NM];
    logic [7:0]        n_peak;
    logic [15:0]       n_ticks;
    logic              n_standby;

    // result register
    logic       r_out_valid;
    logic [7:0] r_duty [NM];
    logic [1:0] r_dir [NM];
    logic       r_out_standby;
    logic [7:0] r_out_peak;
    logic       r_moving;

    logic [7:0] n_duty [NM];
    logic [1:0] n_dir [NM];
    logic       n_moving;

    logic                 adv;
    fwrmd_pkg::t_speed    cmd_tgt [NM];
    fwrmd_pkg::t_tgt_ctl  cmd_ctl;
    fwrmd_pkg::t_speed    ramp_nxt [NM];
    logic [16:0]          tick_cnt;
    logic                 ramp_fire;
    logic                 any_active;

    assign adv         = r_in_valid && (!r_out_valid || o_res.ready);
    assign i_cmd.ready = !r_in_valid || adv;

    fwrmd_target u_target (
        .i_action    (r_action),
        .i_motion    (r_motion),
        .i_speed     (r_speed),
        .i_raw       (r_raw),
        .i_max_speed (r_max_speed),
        .o_tgt       (cmd_tgt),
        .o_ctl       (cmd_ctl)
    );

    for (genvar g = 0; g < NM; g++) begin : g_ramp
        fwrmd_ramp u_ramp (
            .i_cur        (r_cur[g]),
            .i_tgt        (r_tgt[g]),
            .i_accel_step (r_accel_step),
            .i_decel_step (r_decel_step),
            .o_nxt        (ramp_nxt[g])
        );
    end

    always_comb begin
        tick_cnt  = 17'(r_ticks) + 17'd1;
        ramp_fire = (tick_cnt >= {1'b0, r_ramp_interval});

        any_active = 1'b0;
        for (int i = 0; i < NM; i++) begin
            if (ramp_nxt[i] != 0 || r_tgt[i] != 0) begin
                any_active = 1'b1;
            end
        end

        n_tgt     = r_tgt;
        n_cur     = r_cur;
        n_peak    = r_peak;
        n_ticks   = r_ticks;
        n_standby = r_standby;

        unique case (fwrmd_pkg::t_action'(r_action)) inside
            fwrmd_pkg::ACT_TICK: begin
                if (ramp_fire) begin
                    n_ticks   = '0;
                    n_cur     = ramp_nxt;
                    n_standby = any_active;
                end else begin
                    n_ticks = tick_cnt[15:0];
                end
            end
            fwrmd_pkg::ACT_MOTION, fwrmd_pkg::ACT_SET_TARGETS, fwrmd_pkg::ACT_GENTLE_STOP: begin
                n_tgt  = cmd_tgt;
                n_peak = cmd_ctl.peak;
                if (cmd_ctl.load && cmd_ctl.peak != 8'd0) begin
                    n_standby = 1'b1;
                end
            end
            fwrmd_pkg::ACT_EMERGENCY_STOP: begin
                for (int i = 0; i < NM; i++) begin
                    n_tgt[i] = '0;
                    n_cur[i] = '0;
                end
                n_peak    = '0;
                n_standby = 1'b0;
            end
            default: begin
            end
        endcase

        // bridge view of the new speeds
        n_moving = 1'b0;
        for (int i = 0; i < NM; i++) begin
            n_duty[i] = fwrmd_pkg::f_mag(n_cur[i]);
            if (n_cur[i] == 0) begin
                n_dir[i] = fwrmd_pkg::DIR_OFF;
            end else if ((n_cur[i] > 0) != r_invert_mask[i]) begin
                n_dir[i] = fwrmd_pkg::DIR_FWD;
            end else begin
                n_dir[i] = fwrmd_pkg::DIR_REV;
            end
            if (n_cur[i] != 0 || n_tgt[i] != 0) begin
                n_moving = 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_max_speed     <= fwrmd_pkg::RST_MAX_SPEED;
            r_accel_step    <= fwrmd_pkg::RST_ACCEL_STEP;
            r_decel_step    <= fwrmd_pkg::RST_DECEL_STEP;
            r_ramp_interval <= fwrmd_pkg::RST_RAMP_INTERVAL;
            r_invert_mask   <= fwrmd_pkg::RST_INVERT_MASK;
        end else if (i_cfg_we) begin
            unique case (i_cfg_index)
                fwrmd_pkg::CFG_MAX_SPEED:     r_max_speed     <= i_cfg_data[7:0];
                fwrmd_pkg::CFG_ACCEL_STEP:    r_accel_step    <= i_cfg_data[7:0];
                fwrmd_pkg::CFG_DECEL_STEP:    r_decel_step    <= i_cfg_data[7:0];
                fwrmd_pkg::CFG_RAMP_INTERVAL: r_ramp_interval <= i_cfg_data;
                fwrmd_pkg::CFG_INVERT_MASK:   r_invert_mask   <= i_cfg_data[3:0];
                default: begin
                end
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid  <= 1'b0;
            r_out_valid <= 1'b0;
            r_peak      <= '0;
            r_ticks     <= '0;
            r_standby   <= 1'b0;
            for (int i = 0; i < NM; i++) begin
                r_tgt[i] <= '0;
                r_cur[i] <= '0;
            end
        end else begin
            if (i_cmd.ready) begin
                r_in_valid <= i_cmd.valid;
            end
            if (adv) begin
                r_out_valid <= 1'b1;
                r_tgt       <= n_tgt;
                r_cur       <= n_cur;
                r_peak      <= n_peak;
                r_ticks     <= n_ticks;
                r_standby   <= n_standby;
            end else if (o_res.ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    // payload registers
    always_ff @(posedge i_clk) begin
        if (i_cmd.valid && i_cmd.ready) begin
            r_action            <= i_cmd.action;
            r_motion            <= i_cmd.motion;
            r_speed             <= i_cmd.speed;
            r_raw[fwrmd_pkg::MOT_FL] <= i_cmd.front_left;
            r_raw[fwrmd_pkg::MOT_RL] <= i_cmd.rear_left;
            r_raw[fwrmd_pkg::MOT_FR] <= i_cmd.front_right;
            r_raw[fwrmd_pkg::MOT_RR] <= i_cmd.rear_right;
        end
        if (adv) begin
            r_duty        <= n_duty;
            r_dir         <= n_dir;
            r_out_standby <= n_standby;
            r_out_peak    <= n_peak;
            r_moving      <= n_moving;
        end
    end

    assign o_res.valid            = r_out_valid;
    assign o_res.duty_front_left  = r_duty[fwrmd_pkg::MOT_FL];
    assign o_res.duty_rear_left   = r_duty[fwrmd_pkg::MOT_RL];
    assign o_res.duty_front_right = r_duty[fwrmd_pkg::MOT_FR];
    assign o_res.duty_rear_right  = r_duty[fwrmd_pkg::MOT_RR];
    assign o_res.dir_front_left   = r_dir[fwrmd_pkg::MOT_FL];
    assign o_res.dir_rear_left    = r_dir[fwrmd_pkg::MOT_RL];
    assign o_res.dir_front_right  = r_dir[fwrmd_pkg::MOT_FR];
    assign o_res.dir_rear_right   = r_dir[fwrmd_pkg::MOT_RR];
    assign o_res.standby_on       = r_out_standby;
    assign o_res.commanded_speed  = r_out_peak;
    assign o_res.moving           = r_moving;

endmodule

[hdl/fwrmd_target.sv]
// command decoder: turns a request into four clamped targets and the peak magnitude
`timescale 1ns / 1ps

module fwrmd_target (
    input  logic [2:0]          i_action,
    input  logic [2:0]          i_motion,
    input  logic [7:0]          i_speed,
    input  logic signed [15:0]  i_raw [fwrmd_pkg::NUM_MOTORS],
    input  logic [7:0]          i_max_speed,
    output fwrmd_pkg::t_speed   o_tgt [fwrmd_pkg::NUM_MOTORS],
    output fwrmd_pkg::t_tgt_ctl o_ctl
);

    function automatic fwrmd_pkg::t_speed f_clamp(input logic signed [15:0] v,
                                                  input logic [7:0] m);
        logic signed [15:0] hi;
        logic signed [15:0] lo;
        fwrmd_pkg::t_speed  r;
        hi = $signed({8'd0, m});
        lo = -hi;
        if (v > hi) begin
            r = hi[8:0];
        end else if (v < lo) begin
            r = lo[8:0];
        end else begin
            r = v[8:0];
        end
        return r;
    endfunction

    logic [7:0]                          s;
    logic [fwrmd_pkg::INNER_PROD_W-1:0]  prod;
    logic [7:0]                          inner;
    fwrmd_pkg::t_speed                   pos_s;
    fwrmd_pkg::t_speed                   neg_s;
    fwrmd_pkg::t_speed                   pos_in;
    logic [7:0]                          m [fwrmd_pkg::NUM_MOTORS];
    logic [7:0]                          p_left;
    logic [7:0]                          p_right;

    always_comb begin
        s      = (i_speed < i_max_speed) ? i_speed : i_max_speed;
        prod   = fwrmd_pkg::INNER_PROD_W'(s) * fwrmd_pkg::INNER_PROD_W'(fwrmd_pkg::INNER_MUL);
        inner  = 8'(prod >> fwrmd_pkg::INNER_SHIFT);
        pos_s  = $signed({1'b0, s});
        neg_s  = -pos_s;
        pos_in = $signed({1'b0, inner});

        for (int i = 0; i < fwrmd_pkg::NUM_MOTORS; i++) begin
            o_tgt[i] = '0;
        end
        o_ctl.load = 1'b0;

        unique case (fwrmd_pkg::t_action'(i_action))
            fwrmd_pkg::ACT_MOTION: begin
                o_ctl.load = 1'b1;
                unique case (fwrmd_pkg::t_motion'(i_motion))
                    fwrmd_pkg::MOV_FORWARD: begin
                        for (int i = 0; i < fwrmd_pkg::NUM_MOTORS; i++) begin
                            o_tgt[i] = pos_s;
                        end
                    end
                    fwrmd_pkg::MOV_BACKWARD: begin
                        for (int i = 0; i < fwrmd_pkg::NUM_MOTORS; i++) begin
                            o_tgt[i] = neg_s;
                        end
                    end
                    fwrmd_pkg::MOV_TURN_LEFT: begin
                        o_tgt[fwrmd_pkg::MOT_FL] = pos_in;
                        o_tgt[fwrmd_pkg::MOT_RL] = pos_in;
                        o_tgt[fwrmd_pkg::MOT_FR] = pos_s;
                        o_tgt[fwrmd_pkg::MOT_RR] = pos_s;
                    end
                    fwrmd_pkg::MOV_TURN_RIGHT: begin
                        o_tgt[fwrmd_pkg::MOT_FL] = pos_s;
                        o_tgt[fwrmd_pkg::MOT_RL] = pos_s;
                        o_tgt[fwrmd_pkg::MOT_FR] = pos_in;
                        o_tgt[fwrmd_pkg::MOT_RR] = pos_in;
                    end
                    fwrmd_pkg::MOV_ROTATE_LEFT: begin
                        o_tgt[fwrmd_pkg::MOT_FL] = neg_s;
                        o_tgt[fwrmd_pkg::MOT_RL] = neg_s;
                        o_tgt[fwrmd_pkg::MOT_FR] = pos_s;
                        o_tgt[fwrmd_pkg::MOT_RR] = pos_s;
                    end
                    fwrmd_pkg::MOV_ROTATE_RIGHT: begin
                        o_tgt[fwrmd_pkg::MOT_FL] = pos_s;
                        o_tgt[fwrmd_pkg::MOT_RL] = pos_s;
                        o_tgt[fwrmd_pkg::MOT_FR] = neg_s;
                        o_tgt[fwrmd_pkg::MOT_RR] = neg_s;
                    end
                    // stop and the unused code both act as a gentle stop
                    default: begin
                    end
                endcase
            end
            fwrmd_pkg::ACT_SET_TARGETS: begin
                o_ctl.load = 1'b1;
                for (int i = 0; i < fwrmd_pkg::NUM_MOTORS; i++) begin
                    o_tgt[i] = f_clamp(i_raw[i], i_max_speed);
                end
            end
            fwrmd_pkg::ACT_GENTLE_STOP: begin
                o_ctl.load = 1'b1;
            end
            default: begin
            end
        endcase

        for (int i = 0; i < fwrmd_pkg::NUM_MOTORS; i++) begin
            m[i] = fwrmd_pkg::f_mag(o_tgt[i]);
        end
        p_left     = (m[0] > m[1]) ? m[0] : m[1];
        p_right    = (m[2] > m[3]) ? m[2] : m[3];
        o_ctl.peak = (p_left > p_right) ? p_left : p_right;
    end

endmodule

[hdl/fwrmd_ramp.sv]
// one motor's slew step: moves the current speed toward its target
`timescale 1ns / 1ps

module fwrmd_ramp (
    input  fwrmd_pkg::t_speed i_cur,
    input  fwrmd_pkg::t_speed i_tgt,
    input  logic [7:0]        i_accel_step,
    input  logic [7:0]        i_decel_step,
    output fwrmd_pkg::t_speed o_nxt
);

    fwrmd_pkg::t_speed  aim;
    logic [7:0]         step;
    logic signed [10:0] cur_x;
    logic signed [10:0] aim_x;
    logic signed [10:0] step_x;
    logic signed [10:0] r;

    always_comb begin
        // opposite signs: head for zero first
        if ((i_cur > 0 && i_tgt < 0) || (i_cur < 0 && i_tgt > 0)) begin
            aim = '0;
        end else begin
            aim = i_tgt;
        end
        step   = (fwrmd_pkg::f_mag(aim) > fwrmd_pkg::f_mag(i_cur)) ? i_accel_step
                                                                    : i_decel_step;
        cur_x  = 11'(i_cur);
        aim_x  = 11'(aim);
        step_x = $signed({3'd0, step});

        if (i_cur == i_tgt) begin
            r = cur_x;
        end else if (cur_x < aim_x) begin
            r = cur_x + step_x;
            if (r > aim_x) begin
                r = aim_x;
            end
        end else begin
            r = cur_x - step_x;
            if (r < aim_x) begin
                r = aim_x;
            end
        end
        o_nxt = r[8:0];
    end

endmodule

[tb/tb_four_wheel_ramped_motor_drive.sv]
// testbench for the four-wheel ramped motor drive: predicts and checks every result
`timescale 1ns / 1ps

module tb_four_wheel_ramped_motor_drive;

    localparam int CYCLE_LIMIT    = 200000;
    localparam int MAX_PRINTED    = 30;
    localparam int TURN_INNER_PCT = 45;
    localparam int PCT_SCALE      = 100;
    localparam int STALL_CYCLES   = 300;
    localparam int NM             = fwrmd_pkg::NUM_MOTORS;

    // action and motion codes outside the defined set
    localparam logic [2:0] ACT_UNUSED_LO  = 3'd5;
    localparam logic [2:0] ACT_UNUSED_MID = 3'd6;
    localparam logic [2:0] ACT_UNUSED_HI  = 3'd7;
    localparam logic [2:0] MOV_UNDEFINED  = 3'd7;

    typedef struct packed {
        logic [2:0]         action;
        logic [2:0]         motion;
        logic [7:0]         speed;
        logic signed [15:0] fl;
        logic signed [15:0] rl;
        logic signed [15:0] fr;
        logic signed [15:0] rr;
    } t_drive_req;

    typedef struct packed {
        logic [3:0][7:0] duty;
        logic [3:0][1:0] dir;
        logic            standby;
        logic [7:0]      commanded;
        logic            moving;
    } t_drive_out;

    logic                              i_clk = 1'b0;
    logic                              i_rst_n;
    logic                              i_cfg_we;
    logic [fwrmd_pkg::CFG_INDEX_W-1:0] i_cfg_index;
    logic [fwrmd_pkg::CFG_DATA_W-1:0]  i_cfg_data;

    fwrmd_cmd_if cmd_if ();
    fwrmd_res_if res_if ();

    four_wheel_ramped_motor_drive u_dut (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_index (i_cfg_index),
        .i_cfg_data  (i_cfg_data),
        .i_cmd       (cmd_if),
        .o_res       (res_if)
    );

    always #6 i_clk = ~i_clk;

    // drive state mirror
    logic [7:0]        max_speed_reg;
    logic [7:0]        accel_reg;
    logic [7:0]        decel_reg;
    logic [15:0]       ramp_interval_reg;
    logic [3:0]        invert_reg;
    fwrmd_pkg::t_speed tgt_spd [NM];
    fwrmd_pkg::t_speed cur_spd [NM];
    logic [7:0]        peak_cmd;
    logic [15:0]       tick_count;
    logic              standby_lvl;

    t_drive_out  pending_outputs [$];

    string motor_name [NM] = '{"front_left", "rear_left", "front_right", "rear_right"};

    int tx_idle_max = 6;
    int rx_idle_max = 6;
    int rx_hold_req = 0;
    int cycle_count = 0;
    int mismatches = 0;
    int requests_sent = 0;
    int unused_actions = 0;
    int results_checked = 0;
    int ramp_updates = 0;
    int input_stall_cycles = 0;

    function automatic int mag_of(input int v);
        return (v < 0) ? -v : v;
    endfunction

    function automatic fwrmd_pkg::t_speed clamp_target(input int v);
        int lim;
        lim = int'(max_speed_reg);
        if (v > lim) begin
            v = lim;
        end else if (v < -lim) begin
            v = -lim;
        end
        return fwrmd_pkg::t_speed'(v);
    endfunction

    function automatic void load_targets(input int a, input int b, input int c, input int d);
        int pk;
        pk = 0;
        tgt_spd[fwrmd_pkg::MOT_FL] = clamp_target(a);
        tgt_spd[fwrmd_pkg::MOT_RL] = clamp_target(b);
        tgt_spd[fwrmd_pkg::MOT_FR] = clamp_target(c);
        tgt_spd[fwrmd_pkg::MOT_RR] = clamp_target(d);
        for (int i = 0; i < NM; i++) begin
            if (mag_of(int'(tgt_spd[i])) > pk) pk = mag_of(int'(tgt_spd[i]));
        end
        peak_cmd = 8'(pk);
        if (pk > 0) standby_lvl = 1'b1;
    endfunction

    function automatic void clear_targets(input logic halt);
        peak_cmd = 8'd0;
        for (int i = 0; i < NM; i++) begin
            tgt_spd[i] = '0;
            if (halt) cur_spd[i] = '0;
        end
        if (halt) standby_lvl = 1'b0;
    endfunction

    // one slew step; a sign change ramps toward zero first
    function automatic int ramp_toward(input int cur, input int tgt);
        int goal;
        int stp;
        int r;
        goal = tgt;
        if (cur == tgt) return cur;
        if ((cur > 0 && tgt < 0) || (cur < 0 && tgt > 0)) goal = 0;
        stp = (mag_of(goal) > mag_of(cur)) ? int'(accel_reg) : int'(decel_reg);
        if (cur < goal) begin
            r = cur + stp;
            return (r < goal) ? r : goal;
        end
        r = cur - stp;
        return (r > goal) ? r : goal;
    endfunction

    function automatic void reset_drive_state();
        max_speed_reg     = fwrmd_pkg::RST_MAX_SPEED;
        accel_reg         = fwrmd_pkg::RST_ACCEL_STEP;
        decel_reg         = fwrmd_pkg::RST_DECEL_STEP;
        ramp_interval_reg = fwrmd_pkg::RST_RAMP_INTERVAL;
        invert_reg        = fwrmd_pkg::RST_INVERT_MASK;
        for (int i = 0; i < NM; i++) begin
            tgt_spd[i] = '0;
            cur_spd[i] = '0;
        end
        peak_cmd    = 8'd0;
        tick_count  = 16'd0;
        standby_lvl = 1'b0;
    endfunction

    // advances the mirror by one request and returns the drive outputs after it
    function automatic t_drive_out predict_drive(input t_drive_req req);
        t_drive_out o;
        int cnt;
        int s;
        int inner;
        int eff;
        logic active;
        case (req.action)
            fwrmd_pkg::ACT_TICK: begin
                cnt = int'(tick_count) + 1;
                if (cnt < int'(ramp_interval_reg)) begin
                    tick_count = 16'(cnt);
                end else begin
                    tick_count = 16'd0;
                    ramp_updates++;
                    active = 1'b0;
                    for (int i = 0; i < NM; i++) begin
                        cur_spd[i] = fwrmd_pkg::t_speed'(ramp_toward(int'(cur_spd[i]),
                                                                     int'(tgt_spd[i])));
                        if (cur_spd[i] != 0 || tgt_spd[i] != 0) active = 1'b1;
                    end
                    standby_lvl = active;
                end
            end
            fwrmd_pkg::ACT_MOTION: begin
                s = (int'(req.speed) < int'(max_speed_reg)) ? int'(req.speed)
                                                            : int'(max_speed_reg);
                inner = s * TURN_INNER_PCT / PCT_SCALE;
                case (req.motion)
                    fwrmd_pkg::MOV_FORWARD:      load_targets(s, s, s, s);
                    fwrmd_pkg::MOV_BACKWARD:     load_targets(-s, -s, -s, -s);
                    fwrmd_pkg::MOV_TURN_LEFT:    load_targets(inner, inner, s, s);
                    fwrmd_pkg::MOV_TURN_RIGHT:   load_targets(s, s, inner, inner);
                    fwrmd_pkg::MOV_ROTATE_LEFT:  load_targets(-s, -s, s, s);
                    fwrmd_pkg::MOV_ROTATE_RIGHT: load_targets(s, s, -s, -s);
                    default:                     clear_targets(1'b0);
                endcase
            end
            fwrmd_pkg::ACT_SET_TARGETS:    load_targets(int'(req.fl), int'(req.rl),
                                                        int'(req.fr), int'(req.rr));
            fwrmd_pkg::ACT_GENTLE_STOP:    clear_targets(1'b0);
            fwrmd_pkg::ACT_EMERGENCY_STOP: clear_targets(1'b1);
            default: ;
        endcase
        o.moving = 1'b0;
        for (int i = 0; i < NM; i++) begin
            eff = invert_reg[i] ? -int'(cur_spd[i]) : int'(cur_spd[i]);
            o.duty[i] = 8'(mag_of(eff));
            o.dir[i]  = (eff > 0) ? fwrmd_pkg::DIR_FWD
                                  : ((eff < 0) ? fwrmd_pkg::DIR_REV : fwrmd_pkg::DIR_OFF);
            if (cur_spd[i] != 0 || tgt_spd[i] != 0) o.moving = 1'b1;
        end
        o.standby   = standby_lvl;
        o.commanded = peak_cmd;
        return o;
    endfunction

    task automatic report_mismatch(input string field, input int got, input int want);
        mismatches++;
        if (mismatches <= MAX_PRINTED) begin
            $display("mismatch at result %0d: %s got %0d want %0d",
                     results_checked, field, got, want);
        end
    endtask

    // request side: predict on every accepted request
    always @(posedge i_clk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count >= CYCLE_LIMIT) begin
            $display("timeout after %0d cycles, %0d results outstanding",
                     cycle_count, pending_outputs.size());
            $display("RESULT: ERROR");
            $finish;
        end
        if (cmd_if.valid === 1'b1 && cmd_if.ready === 1'b0) input_stall_cycles++;
        if (cmd_if.valid === 1'b1 && cmd_if.ready === 1'b1) begin
            pending_outputs.push_back(predict_drive('{cmd_if.action, cmd_if.motion,
                cmd_if.speed, cmd_if.front_left, cmd_if.rear_left, cmd_if.front_right,
                cmd_if.rear_right}));
        end
    end

    // result side: compare against the oldest prediction
    always @(posedge i_clk) begin
        t_drive_out got;
        t_drive_out want;
        if (res_if.valid === 1'b1 && res_if.ready === 1'b1) begin
            got.duty      = {res_if.duty_rear_right, res_if.duty_front_right,
                             res_if.duty_rear_left, res_if.duty_front_left};
            got.dir       = {res_if.dir_rear_right, res_if.dir_front_right,
                             res_if.dir_rear_left, res_if.dir_front_left};
            got.standby   = res_if.standby_on;
            got.commanded = res_if.commanded_speed;
            got.moving    = res_if.moving;
            if (pending_outputs.size() == 0) begin
                report_mismatch("result with no request outstanding", 1, 0);
            end else begin
                want = pending_outputs.pop_front();
                for (int i = 0; i < NM; i++) begin
                    if (got.duty[i] !== want.duty[i])
                        report_mismatch({"duty_", motor_name[i]}, got.duty[i], want.duty[i]);
                    if (got.dir[i] !== want.dir[i])
                        report_mismatch({"dir_", motor_name[i]}, got.dir[i], want.dir[i]);
                end
                if (got.standby !== want.standby)
                    report_mismatch("standby_on", got.standby, want.standby);
                if (got.commanded !== want.commanded)
                    report_mismatch("commanded_speed", got.commanded, want.commanded);
                if (got.moving !== want.moving)
                    report_mismatch("moving", got.moving, want.moving);
                results_checked++;
            end
        end
    end

    // result receiver with random and long hold-offs
    initial begin
        int w;
        res_if.ready = 1'b0;
        wait (i_rst_n === 1'b1);
        forever begin
            w = $urandom_range(0, rx_idle_max);
            if (rx_hold_req > 0) begin
                w = rx_hold_req;
                rx_hold_req = 0;
            end
            repeat (w) begin
                @(negedge i_clk);
                res_if.ready <= 1'b0;
            end
            @(negedge i_clk);
            res_if.ready <= 1'b1;
            do @(posedge i_clk); while (res_if.valid !== 1'b1);
        end
    end

    task automatic send_request(input t_drive_req req);
        int gap;
        gap = $urandom_range(0, tx_idle_max);
        repeat (gap) begin
            @(negedge i_clk);
            cmd_if.valid <= 1'b0;
        end
        @(negedge i_clk);
        cmd_if.valid       <= 1'b1;
        cmd_if.action      <= req.action;
        cmd_if.motion      <= req.motion;
        cmd_if.speed       <= req.speed;
        cmd_if.front_left  <= req.fl;
        cmd_if.rear_left   <= req.rl;
        cmd_if.front_right <= req.fr;
        cmd_if.rear_right  <= req.rr;
        do @(posedge i_clk); while (cmd_if.ready !== 1'b1);
        requests_sent++;
        if (req.action >= ACT_UNUSED_LO) unused_actions++;
    endtask

    task automatic wait_idle();
        @(negedge i_clk);
        cmd_if.valid <= 1'b0;
        while (pending_outputs.size() != 0) @(posedge i_clk);
        repeat (4) @(posedge i_clk);
    endtask

    task automatic write_reg(input logic [fwrmd_pkg::CFG_INDEX_W-1:0] idx,
                             input logic [fwrmd_pkg::CFG_DATA_W-1:0] data);
        @(negedge i_clk);
        i_cfg_we    <= 1'b1;
        i_cfg_index <= idx;
        i_cfg_data  <= data;
        @(posedge i_clk);
        case (idx)
            fwrmd_pkg::CFG_MAX_SPEED:     max_speed_reg     = data[7:0];
            fwrmd_pkg::CFG_ACCEL_STEP:    accel_reg         = data[7:0];
            fwrmd_pkg::CFG_DECEL_STEP:    decel_reg         = data[7:0];
            fwrmd_pkg::CFG_RAMP_INTERVAL: ramp_interval_reg = data;
            fwrmd_pkg::CFG_INVERT_MASK:   invert_reg        = data[3:0];
            default: ;
        endcase
        @(negedge i_clk);
        i_cfg_we <= 1'b0;
    endtask

    task automatic apply_setting(input int max_spd, input int acc, input int dec,
                                 input int interval, input int inv);
        wait_idle();
        write_reg(fwrmd_pkg::CFG_MAX_SPEED, fwrmd_pkg::CFG_DATA_W'(max_spd));
        write_reg(fwrmd_pkg::CFG_ACCEL_STEP, fwrmd_pkg::CFG_DATA_W'(acc));
        write_reg(fwrmd_pkg::CFG_DECEL_STEP, fwrmd_pkg::CFG_DATA_W'(dec));
        write_reg(fwrmd_pkg::CFG_RAMP_INTERVAL, fwrmd_pkg::CFG_DATA_W'(interval));
        write_reg(fwrmd_pkg::CFG_INVERT_MASK, fwrmd_pkg::CFG_DATA_W'(inv));
    endtask

    function automatic t_drive_req make_req(input logic [2:0] act, input logic [2:0] mot,
                                            input int spd, input int a, input int b,
                                            input int c, input int d);
        return '{act, mot, 8'(spd), 16'(a), 16'(b), 16'(c), 16'(d)};
    endfunction

    // mostly near the clamp window, sometimes the full 16-bit range
    function automatic int rand_target();
        int lim;
        lim = int'(max_speed_reg) + 8;
        if ($urandom_range(0, 3) == 0) return int'($urandom_range(0, 65535));
        return int'($urandom_range(0, 2 * lim)) - lim;
    endfunction

    function automatic t_drive_req random_request();
        t_drive_req req;
        int pick;
        req = make_req(fwrmd_pkg::ACT_TICK, 3'($urandom_range(0, 7)), $urandom_range(0, 255),
                       rand_target(), rand_target(), rand_target(), rand_target());
        pick = $urandom_range(0, 99);
        if (pick < 45)       req.action = fwrmd_pkg::ACT_TICK;
        else if (pick < 66)  req.action = fwrmd_pkg::ACT_MOTION;
        else if (pick < 83)  req.action = fwrmd_pkg::ACT_SET_TARGETS;
        else if (pick < 90)  req.action = fwrmd_pkg::ACT_GENTLE_STOP;
        else if (pick < 94)  req.action = fwrmd_pkg::ACT_EMERGENCY_STOP;
        else if (pick < 97)  req.action = 3'($urandom_range(ACT_UNUSED_LO, ACT_UNUSED_HI));
        return req;
    endfunction

    task automatic run_random(input int count);
        repeat (count) send_request(random_request());
    endtask

    task automatic test_directed();
        apply_setting(fwrmd_pkg::RST_MAX_SPEED, fwrmd_pkg::RST_ACCEL_STEP,
                      fwrmd_pkg::RST_DECEL_STEP, 1, 4'b0110);
        send_request(make_req(fwrmd_pkg::ACT_TICK, fwrmd_pkg::MOV_STOP, 0, 0, 0, 0, 0));
        send_request(make_req(fwrmd_pkg::ACT_MOTION, fwrmd_pkg::MOV_FORWARD, 255, 0, 0, 0, 0));
        send_request(make_req(fwrmd_pkg::ACT_TICK, fwrmd_pkg::MOV_STOP, 0, 0, 0, 0, 0));
        send_request(make_req(fwrmd_pkg::ACT_TICK, fwrmd_pkg::MOV_STOP, 0, 0, 0, 0, 0));
        send_request(make_req(fwrmd_pkg::ACT_MOTION, fwrmd_pkg::MOV_TURN_LEFT, 200,
                              0, 0, 0, 0));
        send_request(make_req(fwrmd_pkg::ACT_MOTION, fwrmd_pkg::MOV_TURN_RIGHT, 101,
                              0, 0, 0, 0));
        send_request(make_req(fwrmd_pkg::ACT_MOTION, fwrmd_pkg::MOV_ROTATE_LEFT, 255,
                              0, 0, 0, 0));
        send_request(make_req(fwrmd_pkg::ACT_MOTION, fwrmd_pkg::MOV_ROTATE_RIGHT, 1,
                              0, 0, 0, 0));
        send_request(make_req(fwrmd_pkg::ACT_MOTION, fwrmd_pkg::MOV_BACKWARD, 0, 0, 0, 0, 0));
        send_request(make_req(fwrmd_pkg::ACT_MOTION, fwrmd_pkg::MOV_BACKWARD, 255,
                              0, 0, 0, 0));
        // reversal: ramp through zero before building the other way
        send_request(make_req(fwrmd_pkg::ACT_TICK, fwrmd_pkg::MOV_STOP, 0, 0, 0, 0, 0));
        send_request(make_req(fwrmd_pkg::ACT_MOTION, fwrmd_pkg::MOV_STOP, 255, 0, 0, 0, 0));
        send_request(make_req(fwrmd_pkg::ACT_MOTION, MOV_UNDEFINED, 255, 0, 0, 0, 0));
        send_request(make_req(fwrmd_pkg::ACT_SET_TARGETS, fwrmd_pkg::MOV_STOP, 0,
                              32767, -32768, 0, -1));
        send_request(make_req(fwrmd_pkg::ACT_TICK, fwrmd_pkg::MOV_STOP, 0, 0, 0, 0, 0));
        // all-zero targets leave standby as it is
        send_request(make_req(fwrmd_pkg::ACT_SET_TARGETS, fwrmd_pkg::MOV_STOP, 0,
                              0, 0, 0, 0));
        send_request(make_req(fwrmd_pkg::ACT_SET_TARGETS, fwrmd_pkg::MOV_STOP, 0,
                              255, -255, 256, -256));
        send_request(make_req(fwrmd_pkg::ACT_GENTLE_STOP, fwrmd_pkg::MOV_STOP, 0,
                              0, 0, 0, 0));
        send_request(make_req(fwrmd_pkg::ACT_TICK, fwrmd_pkg::MOV_STOP, 0, 0, 0, 0, 0));
        send_request(make_req(fwrmd_pkg::ACT_EMERGENCY_STOP, fwrmd_pkg::MOV_STOP, 0,
                              0, 0, 0, 0));
        send_request(make_req(ACT_UNUSED_LO, fwrmd_pkg::MOV_FORWARD, 255, -1, -1, -1, -1));
        send_request(make_req(ACT_UNUSED_MID, fwrmd_pkg::MOV_FORWARD, 255,
                              32767, 32767, 32767, 32767));
        send_request(make_req(ACT_UNUSED_HI, fwrmd_pkg::MOV_FORWARD, 255, -32768, 0, 0, 0));
        send_request(make_req(fwrmd_pkg::ACT_TICK, fwrmd_pkg::MOV_STOP, 0, 0, 0, 0, 0));
    endtask

    task automatic test_config_sweep();
        // extreme steps with every motor inverted
        apply_setting(255, 255, 255, 1, 4'hF);
        run_random(120);
        // zero max speed, ramp on every tick
        tx_idle_max = 0;
        rx_idle_max = 0;
        apply_setting(0, 10, 10, 0, 4'h5);
        run_random(100);
        tx_idle_max = 6;
        rx_idle_max = 6;
        apply_setting(100, 1, 1, 2, 4'hA);
        run_random(120);
        // zero steps freeze the currents
        apply_setting(255, 0, 0, 1, 4'h0);
        run_random(60);
        apply_setting(37, 7, 3, 3, 4'h3);
        run_random(120);
        repeat (3) begin
            apply_setting($urandom_range(1, 255), $urandom_range(1, 64),
                          $urandom_range(1, 64), $urandom_range(1, 4), $urandom_range(0, 15));
            run_random(100);
        end
        // longest interval: ticks only count
        apply_setting(200, 16, 32, 65535, 4'hC);
        run_random(60);
    endtask

    task automatic test_backpressure();
        apply_setting(180, 20, 40, 1, 4'h9);
        tx_idle_max = 0;
        rx_hold_req = STALL_CYCLES;
        run_random(80);
        tx_idle_max = 6;
    endtask

    task automatic test_random_mix();
        apply_setting(fwrmd_pkg::RST_MAX_SPEED, fwrmd_pkg::RST_ACCEL_STEP,
                      fwrmd_pkg::RST_DECEL_STEP, fwrmd_pkg::RST_RAMP_INTERVAL,
                      fwrmd_pkg::RST_INVERT_MASK);
        repeat (4) begin
            tx_idle_max = ($urandom_range(0, 3) == 0) ? 0 : 6;
            rx_idle_max = ($urandom_range(0, 3) == 0) ? 0 : 6;
            run_random(50);
        end
        apply_setting($urandom_range(1, 255), $urandom_range(1, 255), $urandom_range(1, 255),
                      $urandom_range(1, 3), $urandom_range(0, 15));
        repeat (4) begin
            tx_idle_max = ($urandom_range(0, 3) == 0) ? 0 : 6;
            rx_idle_max = ($urandom_range(0, 3) == 0) ? 0 : 6;
            run_random(55);
        end
        tx_idle_max = 6;
        rx_idle_max = 6;
    endtask

    initial begin
        i_rst_n            = 1'b0;
        i_cfg_we           = 1'b0;
        i_cfg_index        = '0;
        i_cfg_data         = '0;
        cmd_if.valid       = 1'b0;
        cmd_if.action      = fwrmd_pkg::ACT_TICK;
        cmd_if.motion      = fwrmd_pkg::MOV_STOP;
        cmd_if.speed       = '0;
        cmd_if.front_left  = '0;
        cmd_if.rear_left   = '0;
        cmd_if.front_right = '0;
        cmd_if.rear_right  = '0;
        reset_drive_state();
        repeat (6) @(negedge i_clk);
        i_rst_n <= 1'b1;

        test_directed();
        test_config_sweep();
        test_backpressure();
        test_random_mix();
        wait_idle();
        repeat (8) @(posedge i_clk);

        $display("drive run: %0d requests (%0d unused action codes), %0d results checked",
                 requests_sent, unused_actions, results_checked);
        $display("%0d ramp updates, input held off %0d cycles by result backpressure",
                 ramp_updates, input_stall_cycles);
        if (mismatches == 0) begin
            $display("RESULT: OK");
        end else begin
            $display("%0d mismatches", mismatches);
            $display("RESULT: ERROR");
        end
        $finish;
    end

endmodule
